### rtl/fed_pkg.sv
// shared constants and register codes for the feedback echo delay
`default_nettype none

package fed_pkg;

  localparam int STORE_DEPTH_DEF = 131072;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int DELAY_BITS = 17;
  localparam int GAIN_BITS  = 17;
  localparam int GAIN_FRAC  = 16;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 17;

  // register indexes on the config port
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIX      = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE   = 2'd3;

  localparam logic [GAIN_BITS-1:0]  GAIN_ONE      = 17'h10000;
  localparam logic [DELAY_BITS-1:0] DELAY_RESET   = 17'd48000;
  localparam logic [GAIN_BITS-1:0]  MIX_RESET     = 17'd32768;
  localparam logic [GAIN_BITS-1:0]  FEEDBACK_RESET = 17'd32768;

endpackage

`default_nettype wire

### rtl/fed_in_if.sv
// input sample channel: valid/ready handshake with one signed sample
`default_nettype none

interface fed_in_if #(
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

### rtl/fed_out_if.sv
// output sample channel: valid/ready handshake with one signed sample
`default_nettype none

interface fed_out_if #(
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

### rtl/feedback_echo_delay.sv
// feedback echo delay: circular sample store with feedback and dry/wet mix
//
// audio_in carries one signed sample per item, audio_out one mixed sample per
// item, both valid/ready. an item is taken when valid and ready are high at a
// rising edge of clk. the config port writes one register per cycle while
// cfg_write is high: delay, mix, feedback and enable.
// an accepted item passes through stage 1, stage 2 and the output register
// on its way to audio_out. one item is accepted per cycle while audio_out does
// not stall; the exception is a delay of one sample, where the next item needs
// the value the previous item is still computing, and input then waits while
// that item is in stage 1. the limit is the store's one read and one write
// port and the read-modify-write loop through the feedback multiplier.
// reset (rst, synchronous) empties the pipeline, restores register defaults
// and rewinds the write pointer; store entries not yet written since reset
// read as zero by tracking the pointer and a wrap flag, so no clearing pass.
// when audio_out stalls the whole pipeline holds and audio_in drops ready;
// the output register keeps its item until it is taken.
`default_nettype none

module feedback_echo_delay #(
  parameter int STORE_DEPTH = fed_pkg::STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  fed_in_if.sink                              audio_in,
  fed_out_if.source                           audio_out,
  input  logic                                cfg_write,
  input  logic [fed_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [fed_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import fed_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  // compare width for clamping the delay against the store depth
  localparam int CW = (AW + 1 > DELAY_BITS) ? AW + 1 : DELAY_BITS;
  // product width: signed sample times zero-extended gain
  localparam int PW = SAMPLE_BITS + GAIN_BITS + 1;

  localparam logic signed [PW-1:0] SMAX =
    {{(PW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN =
    {{(PW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [PW-1:0] v);
    logic [PW-1:0] r;
    if (v > SMAX) begin
      r = SMAX;
    end else if (v < SMIN) begin
      r = SMIN;
    end else begin
      r = v;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  // config registers
  logic [DELAY_BITS-1:0] delay_samples;
  logic [GAIN_BITS-1:0]  mix_level;
  logic [GAIN_BITS-1:0]  feedback_gain;
  logic                  delay_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= DELAY_RESET;
      mix_level     <= MIX_RESET;
      feedback_gain <= FEEDBACK_RESET;
      delay_enable  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DELAY:    delay_samples <= cfg_data[DELAY_BITS-1:0];
        REG_MIX:      mix_level     <= cfg_data[GAIN_BITS-1:0];
        REG_FEEDBACK: feedback_gain <= cfg_data[GAIN_BITS-1:0];
        REG_ENABLE:   delay_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // gains above unity saturate to 1.0
  logic [GAIN_BITS-1:0] mix_sat;
  logic [GAIN_BITS-1:0] fb_sat;
  logic [GAIN_BITS-1:0] dry_gain;

  assign mix_sat  = (mix_level > GAIN_ONE) ? GAIN_ONE : mix_level;
  assign fb_sat   = (feedback_gain > GAIN_ONE) ? GAIN_ONE : feedback_gain;
  assign dry_gain = GAIN_ONE - mix_sat;

  // write pointer and wrap flag; wrap flag marks every entry as written
  logic [AW-1:0] wp;
  logic          wrapped;

  // delay clamped to 1 .. STORE_DEPTH
  logic [CW-1:0] dly_ext;
  logic [CW-1:0] dly_clamp;
  logic [AW:0]   dly;
  logic [AW:0]   wp_ext;
  logic [AW:0]   rd_full;
  logic [AW-1:0] rd_addr;
  logic          rd_written;

  assign dly_ext   = CW'(delay_samples);
  assign dly_clamp = (dly_ext == '0) ? CW'(1) :
                     (dly_ext > CW'(STORE_DEPTH)) ? CW'(STORE_DEPTH) : dly_ext;
  assign dly       = dly_clamp[AW:0];
  assign wp_ext    = {1'b0, wp};
  assign rd_full   = (wp_ext >= dly) ? (wp_ext - dly)
                                     : (wp_ext + (AW + 1)'(STORE_DEPTH) - dly);
  assign rd_addr    = rd_full[AW-1:0];
  assign rd_written = wrapped || (rd_addr < wp);

  // pipeline registers
  logic                          s1_valid;
  logic                          s1_en;
  logic signed [SAMPLE_BITS-1:0] s1_dry;
  logic [AW-1:0]                 s1_wp;
  logic                          s1_written;
  logic                          s1_hit;
  logic signed [SAMPLE_BITS-1:0] s1_fwd;
  logic signed [SAMPLE_BITS-1:0] rd_data;

  logic                          s2_valid;
  logic                          s2_en;
  logic signed [SAMPLE_BITS-1:0] s2_dry;
  logic [AW-1:0]                 s2_wp;
  logic signed [PW-1:0]          s2_pfb;
  logic signed [PW-1:0]          s2_pwet;
  logic signed [PW-1:0]          s2_pdry;

  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  logic adv;
  logic hazard;
  logic hit2;
  logic accept;

  // whole pipeline moves when the output register is free or being drained
  assign adv = !out_valid || audio_out.ready;

  // delay of one: the previous item's store value is not ready in time
  assign hazard = delay_enable && s1_valid && s1_en && (s1_wp == rd_addr);
  // stage 2 writes the entry being read at this same edge: forward it
  assign hit2   = s2_valid && s2_en && (s2_wp == rd_addr);

  assign audio_in.ready = adv && !hazard;
  assign accept         = audio_in.valid && audio_in.ready;

  // delay store, one read and one write port
  logic [SAMPLE_BITS-1:0] store [STORE_DEPTH];

  // stage 2 arithmetic
  logic signed [PW-1:0]          dry_x;
  logic signed [PW-1:0]          mix_sum;
  logic signed [SAMPLE_BITS-1:0] stored;
  logic signed [SAMPLE_BITS-1:0] out_next;

  assign dry_x    = PW'(s2_dry);
  assign stored   = sat_sample(dry_x + (s2_pfb >>> GAIN_FRAC));
  assign mix_sum  = (s2_pdry >>> GAIN_FRAC) + (s2_pwet >>> GAIN_FRAC);
  assign out_next = s2_en ? sat_sample(mix_sum) : s2_dry;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= store[rd_addr];
    end
    if (adv && s2_valid && s2_en) begin
      store[s2_wp] <= stored;
    end
  end

  // pointer advance on enabled items only
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
    end else if (accept && delay_enable) begin
      if (wp == AW'(STORE_DEPTH - 1)) begin
        wp      <= '0;
        wrapped <= 1'b1;
      end else begin
        wp <= wp + AW'(1);
      end
    end
  end

  // stage 1: wet sample from store, forward or zero, then the three products
  logic signed [SAMPLE_BITS-1:0] wet;
  logic signed [GAIN_BITS:0]     fb_s;
  logic signed [GAIN_BITS:0]     mix_s;
  logic signed [GAIN_BITS:0]     dry_s;
  logic signed [PW-1:0]          p_fb;
  logic signed [PW-1:0]          p_wet;
  logic signed [PW-1:0]          p_dry;

  assign wet   = s1_hit ? s1_fwd : (s1_written ? rd_data : '0);
  assign fb_s  = {1'b0, fb_sat};
  assign mix_s = {1'b0, mix_sat};
  assign dry_s = {1'b0, dry_gain};
  assign p_fb  = wet * fb_s;
  assign p_wet = wet * mix_s;
  assign p_dry = s1_dry * dry_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= accept;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_en      <= delay_enable;
      s1_dry     <= audio_in.sample_in;
      s1_wp      <= wp;
      s1_written <= rd_written;
      s1_hit     <= hit2;
      s1_fwd     <= stored;
    end
    if (adv) begin
      s2_en      <= s1_en;
      s2_dry     <= s1_dry;
      s2_wp      <= s1_wp;
      s2_pfb     <= p_fb;
      s2_pwet    <= p_wet;
      s2_pdry    <= p_dry;
      out_sample <= out_next;
    end
  end

  assign audio_out.valid      = out_valid;
  assign audio_out.sample_out = out_sample;

endmodule

`default_nettype wire

### bench/feedback_echo_delay_test.sv
// self-checking bench for the feedback echo delay: directed and random phases
`timescale 1ns / 100ps

module feedback_echo_delay_test;
  import fed_pkg::*;

  localparam int STORE_DEPTH = STORE_DEPTH_DEF;
  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;

  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam logic [CFG_DATA_BITS-1:0] REG_FIELD_MAX = '1;

  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 8;         // idle margin after the last owed sample
  localparam int RUN_LIMIT    = 2_000_000; // runaway limit, well above the slowest legal run
  localparam int REPORT_MAX   = 10;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  fed_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) audio_in_ch ();
  fed_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) audio_out_ch ();

  feedback_echo_delay #(
    .STORE_DEPTH(STORE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .audio_in(audio_in_ch),
    .audio_out(audio_out_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // echo predictor: own copy of the registers, the delay line and its pointer
  // ---------------------------------------------------------------------------
  logic [DELAY_BITS-1:0] echo_delay;
  logic [GAIN_BITS-1:0]  echo_mix;
  logic [GAIN_BITS-1:0]  echo_feedback;
  logic                  echo_on;
  sample_t               echo_line [STORE_DEPTH];
  int unsigned           echo_wr_pos;

  // samples still owed by the block, oldest first
  sample_t echo_out_q [$];

  int mismatch_count = 0;
  int cycle_count = 0;

  // idle controls for the two sides, changed per phase
  logic source_idle_on;
  logic sink_idle_on;
  int   sink_hold = 0;

  task automatic clear_predictor();
    foreach (echo_line[i]) echo_line[i] = '0;
    echo_wr_pos   = 0;
    echo_delay    = DELAY_RESET;
    echo_mix      = MIX_RESET;
    echo_feedback = FEEDBACK_RESET;
    echo_on       = 1'b0;
  endtask

  // product with a q1.16 gain back to sample scale, rounding toward minus infinity
  function automatic longint q16_floor(longint x);
    return x >>> GAIN_FRAC;
  endfunction

  function automatic sample_t clamp_sample(longint v);
    if (v > SAMPLE_MAX) return sample_t'(SAMPLE_MAX);
    if (v < SAMPLE_MIN) return sample_t'(SAMPLE_MIN);
    return sample_t'(v);
  endfunction

  function automatic longint clamp_gain(logic [GAIN_BITS-1:0] g);
    return (g > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(g);
  endfunction

  // one item through the echo: read the tap, write back with feedback, mix
  function automatic sample_t echo_mix_sample(sample_t dry_in);
    longint      dry;
    longint      wet;
    longint      mix;
    longint      fb;
    int unsigned span;
    int unsigned rd_pos;
    if (!echo_on) return dry_in;
    dry  = dry_in;
    // zero delay acts as one, anything past the line is clipped to its length
    span = (echo_delay == 0) ? 1 : echo_delay;
    if (span > STORE_DEPTH) span = STORE_DEPTH;
    rd_pos = (echo_wr_pos + STORE_DEPTH - span) % STORE_DEPTH;
    wet  = echo_line[rd_pos];
    mix  = clamp_gain(echo_mix);
    fb   = clamp_gain(echo_feedback);
    echo_line[echo_wr_pos] = clamp_sample(dry + q16_floor(wet * fb));
    echo_wr_pos = (echo_wr_pos + 1) % STORE_DEPTH;
    return clamp_sample(q16_floor(dry * (longint'(GAIN_ONE) - mix)) + q16_floor(wet * mix));
  endfunction

  // ---------------------------------------------------------------------------
  // random shapes
  // ---------------------------------------------------------------------------

  // mostly no gap, often a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return sample_t'(SAMPLE_MAX);
      1:       return sample_t'(SAMPLE_MIN);
      2:       return sample_t'(int'($urandom_range(0, 2000)) - 1000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // mostly short delays so the taps land on samples of the same phase
  function automatic logic [DELAY_BITS-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DELAY_BITS'(1);
      2:       return DELAY_BITS'(2);
      3:       return REG_FIELD_MAX;
      4:       return DELAY_BITS'($urandom_range(1, int'(REG_FIELD_MAX)));
      5, 6:    return DELAY_BITS'($urandom_range(17, 300));
      default: return DELAY_BITS'($urandom_range(3, 16));
    endcase
  endfunction

  // includes gains above unity, which must clip to 1.0
  function automatic logic [GAIN_BITS-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return GAIN_ONE;
      2:       return GAIN_BITS'($urandom_range(int'(GAIN_ONE) + 1, int'(REG_FIELD_MAX)));
      3:       return REG_FIELD_MAX;
      default: return GAIN_BITS'($urandom_range(0, int'(GAIN_ONE)));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // register write, mirrored into the predictor; called only with the block idle
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (index)
      REG_DELAY:    echo_delay    = value[DELAY_BITS-1:0];
      REG_MIX:      echo_mix      = value[GAIN_BITS-1:0];
      REG_FEEDBACK: echo_feedback = value[GAIN_BITS-1:0];
      REG_ENABLE:   echo_on       = value[0];
      default: ;
    endcase
  endtask

  // one input item; entered and left on a rising edge, valid left high
  task automatic send_sample(input sample_t value);
    int gap;
    gap = source_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      audio_in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    audio_in_ch.valid     <= 1'b1;
    audio_in_ch.sample_in <= value;
    // ready seen high mid-cycle means the item goes in at the next edge
    do @(negedge clk); while (!audio_in_ch.ready);
    @(posedge clk);
    echo_out_q.push_back(echo_mix_sample(value));
  endtask

  // stop sending and let the block run dry before anything else changes
  task automatic drain_results();
    audio_in_ch.valid <= 1'b0;
    while (echo_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // output side: ready with random holds, held off only when idling is on
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      audio_out_ch.ready <= 1'b0;
    end else begin
      audio_out_ch.ready <= 1'b1;
      if (sink_idle_on) sink_hold <= pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: sampled mid-cycle, where nothing is moving
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : check_results
    sample_t want;
    if (!rst && audio_out_ch.valid && audio_out_ch.ready) begin
      if (echo_out_q.size() == 0) begin
        if (mismatch_count < REPORT_MAX)
          $display("[%0t] unexpected sample_out %0d with nothing pending",
                   $realtime, audio_out_ch.sample_out);
        mismatch_count++;
      end else begin
        want = echo_out_q.pop_front();
        if (audio_out_ch.sample_out !== want) begin
          if (mismatch_count < REPORT_MAX)
            $display("[%0t] sample_out mismatch: expected %0d (%h), got %0d (%h)",
                     $realtime, want, want, audio_out_ch.sample_out,
                     audio_out_ch.sample_out);
          mismatch_count++;
        end
      end
    end
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("feedback_echo_delay_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // echo off after reset: every item comes straight back
  task automatic test_passthrough();
    send_sample(sample_t'(SAMPLE_MAX));
    send_sample(sample_t'(SAMPLE_MIN));
    send_sample('0);
    send_sample('1);
    send_sample(sample_t'(24'h555555));
    send_sample(sample_t'(24'haaaaaa));
    drain_results();
  endtask

  // only the enable written: long reset delay reads the empty line, half mix
  task automatic test_reset_values();
    write_reg(REG_ENABLE, CFG_DATA_BITS'(1));
    send_sample(sample_t'(SAMPLE_MAX));
    send_sample(sample_t'(SAMPLE_MIN));
    send_sample('1);
    drain_results();
  endtask

  // zero delay acts as one: each item needs the previous item's write
  // full feedback and full wet drive the line into saturation
  task automatic test_single_sample_delay();
    write_reg(REG_DELAY, '0);
    write_reg(REG_MIX, GAIN_ONE);
    write_reg(REG_FEEDBACK, GAIN_ONE);
    repeat (3) send_sample(sample_t'(SAMPLE_MAX));
    repeat (2) send_sample(sample_t'(SAMPLE_MIN));
    send_sample('0);
    drain_results();
    // fully dry, no feedback, explicit delay of one
    write_reg(REG_DELAY, CFG_DATA_BITS'(1));
    write_reg(REG_MIX, '0);
    write_reg(REG_FEEDBACK, '0);
    send_sample(sample_t'(SAMPLE_MIN));
    send_sample(sample_t'(SAMPLE_MAX));
    drain_results();
  endtask

  // gains beyond unity clip to 1.0; output saturates at both rails
  task automatic test_gain_clipping();
    write_reg(REG_DELAY, CFG_DATA_BITS'(2));
    write_reg(REG_MIX, REG_FIELD_MAX);
    write_reg(REG_FEEDBACK, REG_FIELD_MAX);
    repeat (3) send_sample(sample_t'(SAMPLE_MIN));
    send_sample(sample_t'(SAMPLE_MAX));
    send_sample('1);
    send_sample(sample_t'(1));
    drain_results();
  endtask

  // echo off must leave the line and its pointer alone
  task automatic test_bypass_holds_line();
    write_reg(REG_ENABLE, '0);
    send_sample(sample_t'(123456));
    send_sample(sample_t'(-654321));
    drain_results();
    write_reg(REG_MIX, GAIN_ONE);
    write_reg(REG_ENABLE, CFG_DATA_BITS'(1));
    send_sample('0);
    send_sample('0);
    drain_results();
  endtask

  // phases of random settings and random items, with and without idling
  task automatic test_random_phases();
    int sent;
    int burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(10, 60);
      source_idle_on <= ($urandom_range(0, 3) != 0);
      sink_idle_on   <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) != 0) write_reg(REG_DELAY, pick_delay());
      if ($urandom_range(0, 2) != 0) write_reg(REG_MIX, pick_gain());
      if ($urandom_range(0, 2) != 0) write_reg(REG_FEEDBACK, pick_gain());
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_ENABLE, CFG_DATA_BITS'($urandom_range(0, 1)));
      else
        write_reg(REG_ENABLE, CFG_DATA_BITS'(1));
      repeat (burst) send_sample(pick_sample());
      drain_results();
      sent += burst;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    audio_in_ch.valid = 1'b0;
    audio_in_ch.sample_in = '0;
    source_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    clear_predictor();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_passthrough();
    test_reset_values();
    test_single_sample_delay();
    test_gain_clipping();
    test_bypass_holds_line();
    test_random_phases();

    if (mismatch_count == 0)
      $display("feedback_echo_delay_test passed");
    else
      $display("feedback_echo_delay_test failed");
    $finish;
  end

endmodule

### files.f
rtl/fed_pkg.sv
rtl/fed_in_if.sv
rtl/fed_out_if.sv
rtl/feedback_echo_delay.sv
bench/feedback_echo_delay_test.sv
